// ----- hdl/ngr_pkg.sv -----
// ----------------------------------------------------------------------------
// ngr_pkg
// Shared types and constants of the nearest neighbor gridder.
// ----------------------------------------------------------------------------
package ngr_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned MAX_GRID   = 64;
  localparam int unsigned GRID_W     = 7;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned LAT_W      = 30;
  localparam int unsigned LON_W      = 31;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned STS_W      = 3;
  localparam int unsigned FUNC_W     = 2;
  // dividend width: longitude span times the largest index
  localparam int unsigned PROD_W     = LON_W + IDX_W;
  localparam int unsigned DCNT_W     = $clog2(PROD_W);
  localparam int unsigned RAM_W      = LAT_W + LON_W + VAL_W;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(30);
  localparam logic [GRID_W-1:0] GRID_LOW   = GRID_W'(2);
  localparam logic [GRID_W-1:0] GRID_HIGH  = GRID_W'(MAX_GRID);

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_QUERY = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_DIV   = 6'b000100,
    S_SETUP = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic scan_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic query_go;
    logic div_last;
    logic scan_idle;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/nearest_neighbor_gridder.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_gridder
// Stores scattered points and returns the value of the stored point nearest
// to an evenly spaced grid position between the point bounds.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o | func, point fields, grid row/col
//  out     | output    | out_valid_o/out_stall_i | status, cell fields, count
//  cfg     | input     | cfg_valid_i/cfg_ready_o | grid_points (7 bits)
//
// Clear, load and unused codes skip the multiply, divide and scan states.
// A query in range of a non-empty store runs 1 multiply, 37 restoring
// divide steps (one bit a cycle), then one store read a cycle for each
// of the N stored points and a 3-deep distance pipeline.
// Reset is asynchronous, active low; the point store needs no clearing pass.
// The output register frees the input side: a new transaction is taken while
// a result waits; only a second finished result waits on out_stall_i.
// ----------------------------------------------------------------------------
module nearest_neighbor_gridder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ngr_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [ngr_pkg::LAT_W-1:0]    point_lat_i,
  input  logic signed [ngr_pkg::LON_W-1:0]    point_lon_i,
  input  logic signed [ngr_pkg::VAL_W-1:0]    point_value_i,
  input  logic                                point_valid_i,
  input  logic [ngr_pkg::IDX_W-1:0]           grid_row_i,
  input  logic [ngr_pkg::IDX_W-1:0]           grid_col_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ngr_pkg::STS_W-1:0]           status_o,
  output logic signed [ngr_pkg::VAL_W-1:0]    cell_value_o,
  output logic signed [ngr_pkg::LAT_W-1:0]    cell_lat_o,
  output logic signed [ngr_pkg::LON_W-1:0]    cell_lon_o,
  output logic [ngr_pkg::CNT_W-1:0]           stored_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ngr_pkg::GRID_W-1:0]          cfg_data_i
);
  import ngr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration must only be written while idle; the block does not enforce this, so always take it
  assign cfg_ready_o = 1'b1;

  ngr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ngr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_data_i     (cfg_data_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .func_i         (func_i),
    .point_lat_i    (point_lat_i),
    .point_lon_i    (point_lon_i),
    .point_value_i  (point_value_i),
    .point_valid_i  (point_valid_i),
    .grid_row_i     (grid_row_i),
    .grid_col_i     (grid_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .cell_value_o   (cell_value_o),
    .cell_lat_o     (cell_lat_o),
    .cell_lon_o     (cell_lon_o),
    .stored_count_o (stored_count_o)
  );

endmodule

// ----- hdl/ngr_ram.sv -----
// ----------------------------------------------------------------------------
// ngr_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ngr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/ngr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ngr_ctrl
// Sequencer: accept, multiply, divide, scan, deliver.
// ----------------------------------------------------------------------------
module ngr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ngr_pkg::sts_t sts_i,
  output ngr_pkg::cmd_t cmd_o
);
  import ngr_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.query_go ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.scan_start = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_idle) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");

  a_div_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_DIV))
    else $error("divide did not follow multiply");

  a_scan_after_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETUP) |=> (state_q == S_SCAN))
    else $error("scan did not follow setup");

endmodule

// ----- hdl/ngr_dp.sv -----
// ----------------------------------------------------------------------------
// ngr_dp
// Point store, bounds, grid divider, distance pipeline and result register.
// ----------------------------------------------------------------------------
module ngr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ngr_pkg::cmd_t                       cmd_i,
  output ngr_pkg::sts_t                       sts_o,
  input  logic [ngr_pkg::GRID_W-1:0]          cfg_data_i,
  input  logic                                cfg_we_i,
  input  logic [ngr_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [ngr_pkg::LAT_W-1:0]    point_lat_i,
  input  logic signed [ngr_pkg::LON_W-1:0]    point_lon_i,
  input  logic signed [ngr_pkg::VAL_W-1:0]    point_value_i,
  input  logic                                point_valid_i,
  input  logic [ngr_pkg::IDX_W-1:0]           grid_row_i,
  input  logic [ngr_pkg::IDX_W-1:0]           grid_col_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ngr_pkg::STS_W-1:0]           status_o,
  output logic signed [ngr_pkg::VAL_W-1:0]    cell_value_o,
  output logic signed [ngr_pkg::LAT_W-1:0]    cell_lat_o,
  output logic signed [ngr_pkg::LON_W-1:0]    cell_lon_o,
  output logic [ngr_pkg::CNT_W-1:0]           stored_count_o
);
  import ngr_pkg::*;

  // configuration and store bookkeeping
  logic [GRID_W-1:0]       grid_q;
  logic [CNT_W-1:0]        total_q;
  logic signed [LAT_W-1:0] lat_lo_q, lat_hi_q;
  logic signed [LON_W-1:0] lon_lo_q, lon_hi_q;
  logic [IDX_W-1:0]        row_q, col_q;

  // pending result
  status_e                 res_sts_q;
  logic signed [VAL_W-1:0] res_val_q;
  logic signed [LAT_W-1:0] res_lat_q;
  logic signed [LON_W-1:0] res_lon_q;

  // output register
  logic                    out_valid_q;
  logic [STS_W-1:0]        out_sts_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic signed [LAT_W-1:0] out_lat_q;
  logic signed [LON_W-1:0] out_lon_q;
  logic [CNT_W-1:0]        out_cnt_q;

  // divider
  logic [PROD_W-1:0] qlat_q, qlon_q;
  logic [IDX_W-1:0]  rlat_q, rlon_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [IDX_W:0]    rlat_sh, rlon_sh;
  logic              ge_lat, ge_lon;

  // scan pipeline
  logic              scan_act_q, first_q;
  logic [ADDR_W-1:0] scan_idx_q;
  logic              v1_q, v2_q, v3_q;
  logic [LAT_W:0]    dlat_q;
  logic [LON_W:0]    dlon_q;
  logic signed [VAL_W-1:0] val2_q, val3_q;
  logic [2*LAT_W+1:0] sqlat_q;
  logic [2*LON_W+1:0] sqlon_q;
  logic [2*LON_W+2:0] best_q, dist_sum;

  logic [GRID_W-1:0]       n_eff;
  logic [IDX_W-1:0]        nm1;
  logic                    in_range, full;
  logic [LAT_W-1:0]        span_lat;
  logic [LON_W-1:0]        span_lon;
  logic signed [LAT_W-1:0] glat;
  logic signed [LON_W-1:0] glon;
  logic                    wr_en;
  logic [RAM_W-1:0]        rd_data;
  logic signed [LAT_W-1:0] rd_lat;
  logic signed [LON_W-1:0] rd_lon;
  logic signed [VAL_W-1:0] rd_val;
  logic signed [LAT_W:0]   dlat_s;
  logic signed [LON_W:0]   dlon_s;

  always_comb begin
    n_eff = grid_q;
    if (grid_q < GRID_LOW) n_eff = GRID_LOW;
    if (grid_q > GRID_HIGH) n_eff = GRID_HIGH;
  end
  assign nm1      = IDX_W'(n_eff - GRID_W'(1));
  assign in_range = ({1'b0, grid_row_i} < n_eff) && ({1'b0, grid_col_i} < n_eff);
  assign full     = (total_q == CNT_W'(MAX_POINTS));
  assign span_lat = LAT_W'(lat_hi_q - lat_lo_q);
  assign span_lon = LON_W'(lon_hi_q - lon_lo_q);
  // quotient never exceeds the span, so wrapped addition is exact
  assign glat     = lat_lo_q + $signed(qlat_q[LAT_W-1:0]);
  assign glon     = lon_lo_q + $signed(qlon_q[LON_W-1:0]);

  assign rlat_sh = {rlat_q, qlat_q[PROD_W-1]};
  assign rlon_sh = {rlon_q, qlon_q[PROD_W-1]};
  assign ge_lat  = rlat_sh >= {1'b0, nm1};
  assign ge_lon  = rlon_sh >= {1'b0, nm1};

  assign wr_en = cmd_i.accept && (func_e'(func_i) == FN_LOAD) && point_valid_i && !full;

  ngr_ram #(.Width(RAM_W), .Depth(MAX_POINTS)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (total_q[ADDR_W-1:0]),
    .wr_data_i ({point_lat_i, point_lon_i, point_value_i}),
    .rd_addr_i (scan_idx_q),
    .rd_data_o (rd_data)
  );

  assign rd_lat   = $signed(rd_data[RAM_W-1 -: LAT_W]);
  assign rd_lon   = $signed(rd_data[VAL_W +: LON_W]);
  assign rd_val   = $signed(rd_data[VAL_W-1:0]);
  assign dlat_s   = (LAT_W+1)'(rd_lat) - (LAT_W+1)'(res_lat_q);
  assign dlon_s   = (LON_W+1)'(rd_lon) - (LON_W+1)'(res_lon_q);
  assign dist_sum = (2*LON_W+3)'(sqlon_q) + (2*LON_W+3)'(sqlat_q);

  // config, bounds, count and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q      <= GRID_RESET;
      total_q     <= '0;
      lat_lo_q    <= '0;
      lat_hi_q    <= '0;
      lon_lo_q    <= '0;
      lon_hi_q    <= '0;
      out_valid_q <= 1'b0;
      scan_act_q  <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      first_q     <= 1'b0;
      dcnt_q      <= '0;
      scan_idx_q  <= '0;
    end else begin
      if (cfg_we_i) grid_q <= cfg_data_i;
      if (cmd_i.accept && (func_e'(func_i) == FN_CLEAR)) begin
        total_q  <= '0;
        lat_lo_q <= '0;
        lat_hi_q <= '0;
        lon_lo_q <= '0;
        lon_hi_q <= '0;
      end
      if (wr_en) begin
        total_q <= total_q + CNT_W'(1);
        if (total_q == '0) begin
          lat_lo_q <= point_lat_i;
          lat_hi_q <= point_lat_i;
          lon_lo_q <= point_lon_i;
          lon_hi_q <= point_lon_i;
        end else begin
          if (point_lat_i < lat_lo_q) lat_lo_q <= point_lat_i;
          if (point_lat_i > lat_hi_q) lat_hi_q <= point_lat_i;
          if (point_lon_i < lon_lo_q) lon_lo_q <= point_lon_i;
          if (point_lon_i > lon_hi_q) lon_hi_q <= point_lon_i;
        end
      end
      // hold the result until taken
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (cmd_i.mul) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);

      // issue one read address a cycle
      v1_q <= scan_act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.scan_start) begin
        scan_act_q <= 1'b1;
        scan_idx_q <= '0;
        first_q    <= 1'b1;
      end else begin
        if (scan_act_q) begin
          scan_idx_q <= scan_idx_q + ADDR_W'(1);
          if ({1'b0, scan_idx_q} == total_q - CNT_W'(1)) scan_act_q <= 1'b0;
        end
        if (v3_q) first_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q     <= grid_row_i;
      col_q     <= grid_col_i;
      res_val_q <= '0;
      res_lat_q <= '0;
      res_lon_q <= '0;
      case (func_e'(func_i))
        FN_LOAD: begin
          if (!point_valid_i) res_sts_q <= ST_INVALID;
          else if (full) res_sts_q <= ST_FULL;
          else res_sts_q <= ST_OK;
        end
        FN_QUERY: begin
          if (total_q == '0) res_sts_q <= ST_EMPTY;
          else if (!in_range) res_sts_q <= ST_RANGE;
          else res_sts_q <= ST_OK;
        end
        default: res_sts_q <= ST_OK;
      endcase
    end
    if (cmd_i.mul) begin
      qlat_q <= PROD_W'(span_lat) * PROD_W'(row_q);
      qlon_q <= PROD_W'(span_lon) * PROD_W'(col_q);
      rlat_q <= '0;
      rlon_q <= '0;
    end else if (cmd_i.div_step) begin
      qlat_q <= {qlat_q[PROD_W-2:0], ge_lat};
      qlon_q <= {qlon_q[PROD_W-2:0], ge_lon};
      rlat_q <= ge_lat ? IDX_W'(rlat_sh - {1'b0, nm1}) : IDX_W'(rlat_sh);
      rlon_q <= ge_lon ? IDX_W'(rlon_sh - {1'b0, nm1}) : IDX_W'(rlon_sh);
    end
    if (cmd_i.scan_start) begin
      res_lat_q <= glat;
      res_lon_q <= glon;
    end
    // distance pipeline: difference, square, compare
    dlat_q  <= dlat_s[LAT_W] ? (LAT_W+1)'(-dlat_s) : (LAT_W+1)'(dlat_s);
    dlon_q  <= dlon_s[LON_W] ? (LON_W+1)'(-dlon_s) : (LON_W+1)'(dlon_s);
    val2_q  <= rd_val;
    sqlat_q <= (2*LAT_W+2)'(dlat_q) * (2*LAT_W+2)'(dlat_q);
    sqlon_q <= (2*LON_W+2)'(dlon_q) * (2*LON_W+2)'(dlon_q);
    val3_q  <= val2_q;
    if (v3_q && (first_q || dist_sum < best_q)) begin
      best_q    <= dist_sum;
      res_val_q <= val3_q;
    end
    if (cmd_i.load_out) begin
      out_sts_q <= res_sts_q;
      out_val_q <= res_val_q;
      out_lat_q <= res_lat_q;
      out_lon_q <= res_lon_q;
      out_cnt_q <= total_q;
    end
  end

  assign sts_o.query_go  = (func_e'(func_i) == FN_QUERY) && (total_q != '0) && in_range;
  assign sts_o.div_last  = (dcnt_q == DCNT_W'(PROD_W - 1));
  assign sts_o.scan_idle = !scan_act_q && !v1_q && !v2_q && !v3_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_sts_q;
  assign cell_value_o   = out_val_q;
  assign cell_lat_o     = out_lat_q;
  assign cell_lon_o     = out_lon_q;
  assign stored_count_o = out_cnt_q;

  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lat_lo_q <= lat_hi_q) && (lon_lo_q <= lon_hi_q))
    else $error("bounds out of order");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_act_q |-> ({1'b0, scan_idx_q} < total_q))
    else $error("scan reads beyond stored points");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sts_o.scan_idle |-> !wr_en)
    else $error("store written during scan");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: nearest neighbor gridder testbench
// Drives clear, load, query and unused transactions and sets the grid size
// over the configuration port. A behavioral model of the point store, the
// bounds and the nearest-point scan predicts each result. Each result is
// checked field by field, in order, with and without random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ngr_pkg::*;

  // one input transaction
  typedef struct {
    func_e                   func;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [VAL_W-1:0] val;
    logic                    ok;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
  } point_cmd_t;

  // one result transaction
  typedef struct {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] value;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [CNT_W-1:0]        count;
  } cell_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i = '0;
  logic signed [LAT_W-1:0] point_lat_i = '0;
  logic signed [LON_W-1:0] point_lon_i = '0;
  logic signed [VAL_W-1:0] point_value_i = '0;
  logic                    point_valid_i = 1'b0;
  logic [IDX_W-1:0]        grid_row_i = '0;
  logic [IDX_W-1:0]        grid_col_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STS_W-1:0]        status_o;
  logic signed [VAL_W-1:0] cell_value_o;
  logic signed [LAT_W-1:0] cell_lat_o;
  logic signed [LON_W-1:0] cell_lon_o;
  logic [CNT_W-1:0]        stored_count_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [GRID_W-1:0]       cfg_data_i = '0;

  nearest_neighbor_gridder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .point_lat_i    (point_lat_i),
    .point_lon_i    (point_lon_i),
    .point_value_i  (point_value_i),
    .point_valid_i  (point_valid_i),
    .grid_row_i     (grid_row_i),
    .grid_col_i     (grid_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .cell_value_o   (cell_value_o),
    .cell_lat_o     (cell_lat_o),
    .cell_lon_o     (cell_lon_o),
    .stored_count_o (stored_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Gridder model: point store, bounds and grid size register
  // --------------------------------------------------------------------------
  longint            pt_lat [MAX_POINTS];
  longint            pt_lon [MAX_POINTS];
  longint            pt_val [MAX_POINTS];
  int unsigned       pt_count;
  longint            lat_min, lat_max, lon_min, lon_max;
  logic [GRID_W-1:0] grid_reg = GRID_RESET;

  cell_result_t pending_cells[$];
  int           error_count = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  out_hold_pct = 0;

  // effective grid size: clamp the register into 2..MAX_GRID
  function automatic int unsigned grid_cells();
    if (grid_reg < GRID_LOW) return 32'(GRID_LOW);
    if (grid_reg > GRID_HIGH) return 32'(GRID_HIGH);
    return 32'(grid_reg);
  endfunction

  function automatic longint grid_pos(longint lo, longint hi, int unsigned idx,
                                      int unsigned n);
    return lo + ((hi - lo) * longint'(idx)) / longint'(n - 1);
  endfunction

  function automatic longint unsigned square_abs(longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : d;
    return a * a;
  endfunction

  // apply one transaction to the model and queue the result it causes
  function automatic void predict_cell(point_cmd_t c);
    cell_result_t    r;
    int unsigned     n;
    longint          glat, glon;
    longint unsigned sq_dist, best;
    r = '{ST_OK, '0, '0, '0, '0};
    n = grid_cells();
    case (c.func)
      FN_CLEAR: begin
        pt_count = 0;
        lat_min = 0; lat_max = 0; lon_min = 0; lon_max = 0;
      end
      FN_LOAD: begin
        if (!c.ok) begin
          r.status = ST_INVALID;
        end else if (pt_count >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          pt_lat[pt_count] = longint'(c.lat);
          pt_lon[pt_count] = longint'(c.lon);
          pt_val[pt_count] = longint'(c.val);
          if (pt_count == 0) begin
            lat_min = longint'(c.lat); lat_max = longint'(c.lat);
            lon_min = longint'(c.lon); lon_max = longint'(c.lon);
          end else begin
            if (c.lat < lat_min) lat_min = longint'(c.lat);
            if (c.lat > lat_max) lat_max = longint'(c.lat);
            if (c.lon < lon_min) lon_min = longint'(c.lon);
            if (c.lon > lon_max) lon_max = longint'(c.lon);
          end
          pt_count++;
        end
      end
      FN_QUERY: begin
        if (pt_count == 0) begin
          r.status = ST_EMPTY;
        end else if (c.row >= n || c.col >= n) begin
          r.status = ST_RANGE;
        end else begin
          glat = grid_pos(lat_min, lat_max, c.row, n);
          glon = grid_pos(lon_min, lon_max, c.col, n);
          best = 0;
          // scan in load order; strict less-than keeps the first on ties
          for (int k = 0; k < pt_count; k++) begin
            sq_dist = square_abs(pt_lat[k] - glat) + square_abs(pt_lon[k] - glon);
            if (k == 0 || sq_dist < best) begin
              best = sq_dist;
              r.value = VAL_W'(pt_val[k]);
            end
          end
          r.lat = LAT_W'(glat);
          r.lon = LON_W'(glon);
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(pt_count);
    pending_cells = {pending_cells, r};
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    error_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // randomly hold off the output channel
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_hold_pct);
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    cell_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        e = pending_cells.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
        if (cell_value_o !== e.value)
          report_mismatch($sformatf("cell_value %0d, want %0d", cell_value_o, e.value));
        if (cell_lat_o !== e.lat)
          report_mismatch($sformatf("cell_lat %0d, want %0d", cell_lat_o, e.lat));
        if (cell_lon_o !== e.lon)
          report_mismatch($sformatf("cell_lon %0d, want %0d", cell_lon_o, e.lon));
        if (stored_count_o !== e.count)
          report_mismatch($sformatf("stored_count %0d, want %0d",
                                    stored_count_o, e.count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // send one transaction; valid stays high after acceptance so back-to-back
  // items never lower and raise it in one step
  task automatic send_cmd(point_cmd_t c);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= c.func;
    point_lat_i   <= c.lat;
    point_lon_i   <= c.lon;
    point_value_i <= c.val;
    point_valid_i <= c.ok;
    grid_row_i    <= c.row;
    grid_col_i    <= c.col;
    do @(posedge clk_i); while (in_stall_o);
    predict_cell(c);
  endtask

  // drop valid and wait for every pending result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cells.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [GRID_W-1:0] v);
    drain_results();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grid_reg = v;
  endtask

  function automatic point_cmd_t mk_cmd(func_e f, longint lat = 0, longint lon = 0,
                                        longint val = 0, logic ok = 1'b1,
                                        int unsigned row = 0, int unsigned col = 0);
    point_cmd_t c;
    c.func = f;
    c.lat  = LAT_W'(lat);
    c.lon  = LON_W'(lon);
    c.val  = VAL_W'(val);
    c.ok   = ok;
    c.row  = IDX_W'(row);
    c.col  = IDX_W'(col);
    return c;
  endfunction

  // random point, lat in +-377487360 and lon in +-754974720, random junk elsewhere
  function automatic point_cmd_t rand_load(logic ok);
    point_cmd_t c;
    c = mk_cmd(FN_LOAD, longint'($urandom_range(754974720)) - 377487360,
               longint'($urandom_range(1509949440)) - 754974720,
               int'($urandom), ok, $urandom_range(63), $urandom_range(63));
    return c;
  endfunction

  function automatic point_cmd_t rand_query();
    int unsigned row, col;
    if ($urandom_range(9) == 0) begin
      row = $urandom_range(63);
      col = $urandom_range(63);
    end else begin
      row = $urandom_range(grid_cells() - 1);
      col = $urandom_range(grid_cells() - 1);
    end
    return mk_cmd(FN_QUERY, int'($urandom), int'($urandom), int'($urandom),
                  $urandom_range(1), row, col);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty store, unused code, invalid point, extreme coordinates and values
  task automatic test_directed();
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(FN_NOP, -1, -1, -1, 1'b1, 63, 63));
    send_cmd(mk_cmd(FN_LOAD, 5, 5, 7, 1'b0));
    send_cmd(mk_cmd(FN_LOAD, 377487360, 754974720, 32'sh7FFFFFFF));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b0, 29, 29));
    send_cmd(mk_cmd(FN_LOAD, -377487360, -754974720, -32'sh80000000));
    send_cmd(mk_cmd(FN_LOAD, 30'sh1FFFFFFF, 0, 1));
    send_cmd(mk_cmd(FN_LOAD, -30'sh20000000, 0, -1));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 29, 29));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 15, 14));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 30, 0));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 0, 63));
    send_cmd(mk_cmd(FN_NOP));
    send_cmd(mk_cmd(FN_CLEAR, -1, -1, -1, 1'b1, 63, 63));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 1, 1));
    // tie: same position twice, first loaded value must win
    send_cmd(mk_cmd(FN_LOAD, 1000, 2000, 11));
    send_cmd(mk_cmd(FN_LOAD, 1000, 2000, 22));
    send_cmd(mk_cmd(FN_LOAD, -1000, -2000, 33));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 29, 29));
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(FN_CLEAR));
    drain_results();
  endtask

  // grid size register at and beyond its clamp limits
  task automatic test_grid_limits();
    logic [GRID_W-1:0] sizes [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
    send_cmd(mk_cmd(FN_LOAD, -4000, 9000, 5));
    send_cmd(mk_cmd(FN_LOAD, 123456, -77777, 6));
    send_cmd(mk_cmd(FN_LOAD, 50, 50, 7));
    foreach (sizes[i]) begin
      write_grid(sizes[i]);
      send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, grid_cells() - 1, 0));
      send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, 0, grid_cells() - 1));
      send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, grid_cells() % 64, 0));
    end
    send_cmd(mk_cmd(FN_CLEAR));
    write_grid(GRID_RESET);
  endtask

  // load a large batch of points and scan it whole
  task automatic test_large_store();
    for (int i = 0; i < 100; i++) send_cmd(rand_load(1'b1));
    send_cmd(rand_load(1'b0));
    send_cmd(rand_query());
    send_cmd(mk_cmd(FN_QUERY, 0, 0, 0, 1'b1, grid_cells() - 1, grid_cells() - 1));
    send_cmd(mk_cmd(FN_CLEAR));
    drain_results();
  endtask

  // sequences of clear, random loads and queries; sent tallies loads plus 6 per sequence
  task automatic test_random(int unsigned item_goal);
    int unsigned sent;
    int unsigned loads;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(3) == 0) begin
        write_grid($urandom_range(7) == 0 ? 7'($urandom_range(127))
                                          : 7'($urandom_range(2, 64)));
      end
      send_cmd(mk_cmd(FN_CLEAR, int'($urandom), int'($urandom), int'($urandom),
                      $urandom_range(1), $urandom_range(63), $urandom_range(63)));
      loads = $urandom_range(1, 40);
      for (int i = 0; i < loads; i++) begin
        send_cmd(rand_load($urandom_range(9) != 0));
        if ($urandom_range(5) == 0) send_cmd(rand_query());
      end
      repeat ($urandom_range(3, 8)) send_cmd(rand_query());
      if ($urandom_range(7) == 0) send_cmd(mk_cmd(FN_NOP, int'($urandom)));
      sent += loads + 6;
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 22;
    out_hold_pct = 64;
    write_grid(GRID_RESET);
    test_directed();
    test_grid_limits();
    test_large_store();
    test_random(80);
    send_gap_pct = 64;
    out_hold_pct = 22;
    test_random(80);
    send_gap_pct = 0;
    out_hold_pct = 0;
    test_random(80);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("nearest_neighbor_gridder verification clean");
    end else begin
      $display("nearest_neighbor_gridder verification failed");
    end
    $finish;
  end

  // hard limit well above the slowest legal run
  initial begin
    #20ms;
    $display("nearest_neighbor_gridder verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ngr_pkg.sv
hdl/ngr_ram.sv
hdl/ngr_ctrl.sv
hdl/ngr_dp.sv
hdl/nearest_neighbor_gridder.sv
bench/tb.sv
